@@ hw/rtl/spsc_pkg.sv @@
package spsc_pkg;

    // Command codes
    localparam logic [2:0] CMD_SET_LIMITS = 3'd0;
    localparam logic [2:0] CMD_PREPARE    = 3'd1;
    localparam logic [2:0] CMD_ATTACH     = 3'd2;
    localparam logic [2:0] CMD_DETACH     = 3'd3;
    localparam logic [2:0] CMD_MOVE       = 3'd4;
    localparam logic [2:0] CMD_TICK       = 3'd5;

    // Status codes
    localparam logic [2:0] STS_OK       = 3'd0;
    localparam logic [2:0] STS_ALREADY  = 3'd1;
    localparam logic [2:0] STS_BAD_CHAN = 3'd2;
    localparam logic [2:0] STS_NOT_PREP = 3'd3;
    localparam logic [2:0] STS_NO_GAP   = 3'd4;
    localparam logic [2:0] STS_NO_REF   = 3'd5;
    localparam logic [2:0] STS_FAULT    = 3'd6;

    // Configuration register indexes
    localparam logic [2:0] REG_ABS_MIN    = 3'd0;
    localparam logic [2:0] REG_ABS_MAX    = 3'd1;
    localparam logic [2:0] REG_MAX_STEP   = 3'd2;
    localparam logic [2:0] REG_CENTER     = 3'd3;
    localparam logic [2:0] REG_REF_WINDOW = 3'd4;

    // Reset values
    localparam logic [14:0] RST_ABS_MIN  = 15'd500;
    localparam logic [14:0] RST_ABS_MAX  = 15'd2500;
    localparam logic [14:0] RST_MAX_STEP = 15'd10;
    localparam logic [14:0] RST_CENTER   = 15'd1500;
    localparam logic [9:0]  RST_WINDOW   = 10'd50;

    localparam logic [14:0] PERIOD_US  = 15'd20000;
    localparam int          MAX_CHAN   = 8;
    localparam int          DUTY_BITS  = 12;
    // ceil(2^35 / 20000): reciprocal for the duty division
    localparam logic [20:0] DUTY_RECIP = 21'd1717987;
    localparam int          RECIP_SHIFT = 35;

    typedef struct packed {
        logic [2:0]  command;
        logic [2:0]  channel;
        logic [14:0] value_us;
        logic [14:0] hard_min_us;
        logic [14:0] hard_max_us;
        logic [14:0] soft_min_us;
        logic [14:0] soft_max_us;
        logic        gap_seen;
        logic        ref_level;
    } t_cmd_word;

    typedef struct packed {
        logic [2:0]           status;
        logic [2:0]           out_channel;
        logic [14:0]          pulse_us;
        logic [DUTY_BITS-1:0] duty;
        logic                 duty_update;
        logic [7:0]           attached_mask;
        logic [7:0]           fault_mask;
        logic                 ref_good;
        logic                 last;
    } t_res_word;

    typedef struct packed {
        logic [14:0] hard_lo;
        logic [14:0] hard_hi;
        logic [14:0] soft_lo;
        logic [14:0] soft_hi;
        logic [14:0] cmd_pos;
        logic [14:0] wr_pos;
        logic [14:0] prep_pos;
    } t_chan_rec;

    function automatic logic [14:0] clamp_us(
        input logic [14:0] abs_min,
        input logic [14:0] abs_max,
        input t_chan_rec   rec,
        input logic [14:0] us
    );
        logic [14:0] lo;
        logic [14:0] hi;
        logic [14:0] res;
        lo = abs_min;
        hi = abs_max;
        if (rec.hard_lo > lo) lo = rec.hard_lo;
        if (rec.hard_hi < hi) hi = rec.hard_hi;
        if (rec.soft_lo > lo) lo = rec.soft_lo;
        if (rec.soft_hi < hi) hi = rec.soft_hi;
        if (lo > hi) begin
            // fall back to hard window, then absolute window
            lo = (rec.hard_lo > abs_min) ? rec.hard_lo : abs_min;
            hi = (rec.hard_hi < abs_max) ? rec.hard_hi : abs_max;
            if (lo > hi) begin
                lo = abs_min;
                hi = abs_max;
            end
        end
        if (us < lo)      res = lo;
        else if (us > hi) res = hi;
        else              res = us;
        return res;
    endfunction

endpackage

@@ hw/rtl/spsc_ram.sv @@
module spsc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/servo_pulse_slew_controller.sv @@
// Servo pulse slew controller. Raise start with a command word while busy is
// low; the block answers with result words on o_res, each marked by o_strobe
// for exactly one cycle, and the receiver must take every word as it comes:
// there is no way to hold results off. Commands 0 to 4 and unknown codes give
// one word each; a frame tick gives CHANNELS words, starting with channel 0,
// one per pass through the states, the final one flagged by last; busy stays
// high until the final word is formed. Each word costs one channel-memory
// read, a clamp stage, a read-modify-write of the channel entry and three
// stages of reciprocal multiplication that turn the pulse into a duty value.
// Configuration writes are taken at any edge with i_cfg_we high but must only
// be issued while busy is low. Limit tables and positions come out of reset
// at the fixed reset values without any clearing pass.
module servo_pulse_slew_controller #(
    parameter int CHANNELS  = 5
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  spsc_pkg::t_cmd_word i_cmd,
    output logic                o_strobe,
    output spsc_pkg::t_res_word o_res,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_idx,
    input  logic [14:0]         i_cfg_data
);

    localparam logic [16:0] DUTY_MAX = 17'((1 << spsc_pkg::DUTY_BITS) - 1);
    localparam logic [2:0]  LAST_CH  = 3'(CHANNELS - 1);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_RD    = 7'b0000010,
        ST_CALC  = 7'b0000100,
        ST_APPLY = 7'b0001000,
        ST_MUL   = 7'b0010000,
        ST_REC   = 7'b0100000,
        ST_FIX   = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    // configuration; the centre only shapes the reset record
    logic [14:0] r_abs_min, r_abs_max, r_max_step;
    logic [9:0]  r_window;

    // flag state
    logic [7:0] r_prep, r_att, r_fault, n_prep, n_att, n_fault;
    logic       r_ref_ok, r_saw_hi, r_saw_lo;
    logic [9:0] r_tick_cnt;
    logic [7:0] r_vld;

    // working registers
    spsc_pkg::t_cmd_word r_in;
    logic                r_tick;
    logic [2:0]          r_ch;
    spsc_pkg::t_chan_rec r_rec;
    logic [14:0]         r_ga, r_gb;
    logic [2:0]          r_status, n_status;
    logic [14:0]         r_pulse, n_pulse;
    logic                r_upd, n_upd;
    logic                r_last, n_last;
    logic [30:0]         r_x;
    logic [16:0]         r_qe;
    logic                r_strobe;
    spsc_pkg::t_res_word r_res;

    // memory
    spsc_pkg::t_chan_rec ram_rdata, ram_wdata, cur_rec, eff_rec, n_rec;
    logic                ram_we;

    spsc_ram #(
        .WIDTH ($bits(spsc_pkg::t_chan_rec)),
        .DEPTH (spsc_pkg::MAX_CHAN)
    ) u_chan_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_ch),
        .i_wdata (ram_wdata),
        .i_raddr (r_ch),
        .o_rdata (ram_rdata)
    );

    logic accept;
    logic good_ch;
    assign accept  = start && !busy;
    assign busy    = (r_state != ST_IDLE);
    assign good_ch = ({1'b0, r_ch} < 4'(CHANNELS));

    // entries never written read as the reset record
    always_comb begin
        if (r_vld[r_ch]) begin
            cur_rec = ram_rdata;
        end else begin
            cur_rec.hard_lo  = spsc_pkg::RST_ABS_MIN;
            cur_rec.hard_hi  = spsc_pkg::RST_ABS_MAX;
            cur_rec.soft_lo  = spsc_pkg::RST_ABS_MIN;
            cur_rec.soft_hi  = spsc_pkg::RST_ABS_MAX;
            cur_rec.cmd_pos  = spsc_pkg::RST_CENTER;
            cur_rec.wr_pos   = spsc_pkg::RST_CENTER;
            cur_rec.prep_pos = spsc_pkg::RST_CENTER;
        end
        eff_rec = cur_rec;
        if (!r_tick && r_in.command == spsc_pkg::CMD_SET_LIMITS) begin
            eff_rec.hard_lo = r_in.hard_min_us;
            eff_rec.hard_hi = r_in.hard_max_us;
            eff_rec.soft_lo = r_in.soft_min_us;
            eff_rec.soft_hi = r_in.soft_max_us;
        end
    end

    // slew arithmetic
    logic signed [16:0] diff, step, ms;
    logic        [14:0] slewed;
    always_comb begin
        diff = 17'($signed({2'b00, r_ga})) - 17'($signed({2'b00, r_rec.wr_pos}));
        ms   = $signed({2'b00, r_max_step});
        if (diff > ms)       step = ms;
        else if (diff < -ms) step = -ms;
        else                 step = diff;
        slewed = 15'(r_rec.wr_pos + 15'(step));
    end

    // command execution
    logic [7:0] bitm;
    always_comb begin
        bitm     = 8'(1) << r_ch;
        n_rec    = r_rec;
        n_prep   = r_prep;
        n_att    = r_att;
        n_fault  = r_fault;
        n_status = spsc_pkg::STS_OK;
        n_pulse  = r_rec.wr_pos;
        n_upd    = 1'b0;
        n_last   = 1'b1;
        ram_we   = 1'b0;
        if (r_tick) begin
            n_last = (r_ch == LAST_CH);
            if ((r_att & bitm) != 8'd0 && diff != 17'sd0) begin
                n_rec.wr_pos = slewed;
                n_upd        = 1'b1;
            end
            n_pulse = n_rec.wr_pos;
            ram_we  = (r_state == ST_APPLY);
        end else if (r_in.command == spsc_pkg::CMD_ATTACH && !r_ref_ok) begin
            n_status = spsc_pkg::STS_NO_REF;
            n_pulse  = good_ch ? r_rec.wr_pos : 15'd0;
        end else if (r_in.command > spsc_pkg::CMD_TICK || !good_ch) begin
            n_status = spsc_pkg::STS_BAD_CHAN;
            n_pulse  = 15'd0;
        end else begin
            ram_we = (r_state == ST_APPLY);
            case (r_in.command)
                spsc_pkg::CMD_SET_LIMITS: begin
                    n_rec.cmd_pos = r_ga;
                    if ((r_prep & bitm) != 8'd0 && (r_att & bitm) == 8'd0
                            && r_gb != r_rec.prep_pos) begin
                        n_rec.prep_pos = r_gb;
                        n_upd          = 1'b1;
                    end
                    n_pulse = n_rec.prep_pos;
                end
                spsc_pkg::CMD_PREPARE: begin
                    if ((r_att & bitm) != 8'd0) begin
                        n_status = spsc_pkg::STS_ALREADY;
                    end else begin
                        n_rec.prep_pos = r_ga;
                        n_prep         = r_prep | bitm;
                        n_upd          = 1'b1;
                    end
                    n_pulse = n_rec.prep_pos;
                end
                spsc_pkg::CMD_ATTACH: begin
                    if ((r_att & bitm) != 8'd0) begin
                        n_status = spsc_pkg::STS_ALREADY;
                    end else if ((r_prep & bitm) == 8'd0) begin
                        n_status = spsc_pkg::STS_NOT_PREP;
                    end else if (!r_in.gap_seen) begin
                        n_status = spsc_pkg::STS_NO_GAP;
                    end else begin
                        n_att         = r_att | bitm;
                        n_prep        = r_prep & ~bitm;
                        n_rec.cmd_pos = r_rec.prep_pos;
                        n_rec.wr_pos  = r_rec.prep_pos;
                    end
                    n_pulse = n_rec.wr_pos;
                end
                spsc_pkg::CMD_DETACH: begin
                    if ((r_att & bitm) == 8'd0) begin
                        n_prep = r_prep & ~bitm;
                    end else if (!r_in.gap_seen) begin
                        n_fault  = r_fault | bitm;
                        n_status = spsc_pkg::STS_FAULT;
                    end else begin
                        n_att   = r_att & ~bitm;
                        n_prep  = r_prep & ~bitm;
                        n_fault = r_fault & ~bitm;
                    end
                end
                default: begin
                    n_rec.cmd_pos = r_ga;
                end
            endcase
        end
    end

    assign ram_wdata = n_rec;

    // sequencing
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (accept) n_state = ST_RD;
            ST_RD:    n_state = ST_CALC;
            ST_CALC:  n_state = ST_APPLY;
            ST_APPLY: n_state = ST_MUL;
            ST_MUL:   n_state = ST_REC;
            ST_REC:   n_state = ST_FIX;
            ST_FIX:   n_state = (r_tick && !r_last) ? ST_RD : ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // duty correction: the reciprocal estimate is at most one too high
    logic [31:0] qe_back;
    logic [16:0] q_fix;
    logic [14:0] p_lim;
    assign qe_back = 32'(r_qe) * 32'(spsc_pkg::PERIOD_US);
    assign q_fix   = (qe_back > 32'(r_x)) ? r_qe - 17'd1 : r_qe;
    assign p_lim   = (r_pulse > spsc_pkg::PERIOD_US) ? spsc_pkg::PERIOD_US : r_pulse;

    // reference supervision, evaluated as a tick is accepted
    logic [9:0] cnt_inc;
    logic       saw_hi_n, saw_lo_n;
    assign cnt_inc  = r_tick_cnt + 10'd1;
    assign saw_hi_n = r_saw_hi | i_cmd.ref_level;
    assign saw_lo_n = r_saw_lo | !i_cmd.ref_level;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_abs_min  <= spsc_pkg::RST_ABS_MIN;
            r_abs_max  <= spsc_pkg::RST_ABS_MAX;
            r_max_step <= spsc_pkg::RST_MAX_STEP;
            r_window   <= spsc_pkg::RST_WINDOW;
            r_prep     <= '0;
            r_att      <= '0;
            r_fault    <= '0;
            r_ref_ok   <= 1'b0;
            r_saw_hi   <= 1'b0;
            r_saw_lo   <= 1'b0;
            r_tick_cnt <= '0;
            r_vld      <= '0;
            r_strobe   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= (r_state == ST_FIX);
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    spsc_pkg::REG_ABS_MIN:    r_abs_min  <= i_cfg_data;
                    spsc_pkg::REG_ABS_MAX:    r_abs_max  <= i_cfg_data;
                    spsc_pkg::REG_MAX_STEP:   r_max_step <= i_cfg_data;
                    spsc_pkg::REG_CENTER:     ;
                    spsc_pkg::REG_REF_WINDOW: r_window   <= i_cfg_data[9:0];
                    default: ;
                endcase
            end
            if (accept && i_cmd.command == spsc_pkg::CMD_TICK) begin
                if (cnt_inc >= r_window) begin
                    r_ref_ok   <= saw_hi_n & saw_lo_n;
                    r_saw_hi   <= 1'b0;
                    r_saw_lo   <= 1'b0;
                    r_tick_cnt <= '0;
                end else begin
                    r_saw_hi   <= saw_hi_n;
                    r_saw_lo   <= saw_lo_n;
                    r_tick_cnt <= cnt_inc;
                end
            end
            if (r_state == ST_APPLY) begin
                r_prep  <= n_prep;
                r_att   <= n_att;
                r_fault <= n_fault;
                if (ram_we) r_vld[r_ch] <= 1'b1;
            end
        end
    end

    // payload path
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_in   <= i_cmd;
                r_tick <= (i_cmd.command == spsc_pkg::CMD_TICK);
                r_ch   <= (i_cmd.command == spsc_pkg::CMD_TICK) ? 3'd0 : i_cmd.channel;
            end
            ST_CALC: begin
                r_rec <= eff_rec;
                r_ga  <= spsc_pkg::clamp_us(r_abs_min, r_abs_max, eff_rec,
                         (r_tick || r_in.command == spsc_pkg::CMD_SET_LIMITS)
                         ? eff_rec.cmd_pos : r_in.value_us);
                r_gb  <= spsc_pkg::clamp_us(r_abs_min, r_abs_max, eff_rec,
                                            eff_rec.prep_pos);
            end
            ST_APPLY: begin
                r_status <= n_status;
                r_pulse  <= n_pulse;
                r_upd    <= n_upd;
                r_last   <= n_last;
            end
            ST_MUL: begin
                r_x <= 31'(32'(p_lim) * 32'(DUTY_MAX));
            end
            ST_REC: begin
                r_qe <= 17'((52'(r_x) * 52'(spsc_pkg::DUTY_RECIP))
                            >> spsc_pkg::RECIP_SHIFT);
            end
            ST_FIX: begin
                r_res.status        <= r_status;
                r_res.out_channel   <= r_tick ? r_ch : r_in.channel;
                r_res.pulse_us      <= r_pulse;
                r_res.duty          <= q_fix[spsc_pkg::DUTY_BITS-1:0];
                r_res.duty_update   <= r_upd;
                r_res.attached_mask <= r_att;
                r_res.fault_mask    <= r_fault;
                r_res.ref_good      <= r_ref_ok;
                r_res.last          <= r_last;
                if (r_tick && !r_last) r_ch <= r_ch + 3'd1;
            end
            default: ;
        endcase
    end

    assign o_strobe = r_strobe;
    assign o_res    = r_res;

    a_strobe_after_fix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(r_state == ST_FIX))
        else $error("strobe without a finished word");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_res.last) |-> (r_state == ST_IDLE))
        else $error("final word while still busy");

    a_accept_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == ST_RD))
        else $error("accepted word did not start a read");

    a_fault_attached: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fault & ~r_att) == 8'd0)
        else $error("fault flag on a detached channel");

    a_prep_att_disjoint: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_prep & r_att) == 8'd0)
        else $error("channel both prepared and attached");

endmodule
